// ===== hw/rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants of the periodic slot timer
// Request and response layouts, command and result codes, sequencer states.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int SLOTS       = 16;
	localparam int HANDLE_BITS = 16;
	localparam int SLOT_BITS   = $clog2(SLOTS);
	localparam int USED_BITS   = SLOT_BITS + 1;
	localparam int IVAL_BITS   = 32;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_FIRE   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [IVAL_BITS-1:0]   interval;
		logic [HANDLE_BITS-1:0] handle;
		logic [4:0]             slot_id;
	} req_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [SLOT_BITS-1:0]   slot;
		logic [HANDLE_BITS-1:0] tag;
		logic                   ok;
		logic                   last;
	} rsp_t;

	typedef struct packed {
		logic                 fire;
		logic [IVAL_BITS-1:0] count;
	} slot_upd_t;

endpackage

// ===== hw/rtl/pst_slot_unit.sv =====
// ----------------------------------------------------------------------------
// pst_slot_unit: shared count update for one timer slot
// Increments a slot count, compares it with the interval and clears it on fire.
// ----------------------------------------------------------------------------
module pst_slot_unit (
	input  logic                           active,
	input  logic [pst_pkg::IVAL_BITS-1:0] count,
	input  logic [pst_pkg::IVAL_BITS-1:0] interval,
	output pst_pkg::slot_upd_t             upd
);

	logic [pst_pkg::IVAL_BITS-1:0] next_count;

	always_comb begin
		next_count = count + pst_pkg::IVAL_BITS'(1);
		upd.fire   = active && (interval != '0) && (next_count == interval);
		upd.count  = upd.fire ? '0 : next_count;
	end

endmodule

// ===== hw/rtl/periodic_slot_timer.sv =====
// ----------------------------------------------------------------------------
// periodic_slot_timer: table of periodic timer slots
// Add and remove requests are answered in the cycle after they are taken.
// A tick request walks the claimed slots through one shared count unit, one
// slot per cycle unless a fire waits on a stalled output. Only one request
// is in work at a time. Reset clears the handles and the slot usage count;
// counts and intervals are written by add before they are read.
// ----------------------------------------------------------------------------
module periodic_slot_timer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pst_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pst_pkg::rsp_t   rsp
);

	pst_pkg::state_t state_q, state_d;

	logic [pst_pkg::HANDLE_BITS-1:0] handle_q   [pst_pkg::SLOTS];
	logic [pst_pkg::IVAL_BITS-1:0]   count_q    [pst_pkg::SLOTS];
	logic [pst_pkg::IVAL_BITS-1:0]   interval_q [pst_pkg::SLOTS];
	logic [pst_pkg::USED_BITS-1:0]   used_q;
	logic [pst_pkg::SLOT_BITS-1:0]   idx_q;

	pst_pkg::rsp_t rsp_q, out_d, pend_q;
	logic          rsp_valid_q, pend_valid_q;

	pst_pkg::slot_upd_t upd;
	logic slot_active, out_free, out_load, step, visit_last;
	logic add_we, rem_we, idx_clr, has_room, id_ok;

	assign slot_active = handle_q[idx_q] != '0;
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign req_ready   = (state_q == pst_pkg::ST_IDLE) && out_free;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;
	assign has_room    = used_q < pst_pkg::USED_BITS'(pst_pkg::SLOTS);
	assign id_ok       = pst_pkg::USED_BITS'(req.slot_id) < used_q;
	assign visit_last  = (pst_pkg::USED_BITS'(idx_q) + pst_pkg::USED_BITS'(1)) == used_q;

	pst_slot_unit u_slot_unit (
		.active   (slot_active),
		.count    (count_q[idx_q]),
		.interval (interval_q[idx_q]),
		.upd      (upd)
	);

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_d    = pend_q;
		step     = 1'b0;
		add_we   = 1'b0;
		rem_we   = 1'b0;
		idx_clr  = 1'b0;
		case (state_q)
			pst_pkg::ST_IDLE: begin
				if (req_valid && req_ready) begin
					case (req.cmd)
						pst_pkg::CMD_TICK: begin
							idx_clr = 1'b1;
							state_d = (used_q == '0) ? pst_pkg::ST_FLUSH : pst_pkg::ST_TICK;
						end
						pst_pkg::CMD_ADD: begin
							out_load   = 1'b1;
							add_we     = has_room;
							out_d.kind = pst_pkg::KIND_ADD;
							out_d.slot = has_room ? used_q[pst_pkg::SLOT_BITS-1:0] : '0;
							out_d.tag  = '0;
							out_d.ok   = has_room;
							out_d.last = 1'b1;
						end
						pst_pkg::CMD_REMOVE: begin
							out_load   = 1'b1;
							rem_we     = id_ok;
							out_d.kind = pst_pkg::KIND_REMOVE;
							out_d.slot = '0;
							out_d.tag  = '0;
							out_d.ok   = id_ok;
							out_d.last = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			pst_pkg::ST_TICK: begin
				if (!(upd.fire && pend_valid_q && !out_free)) begin
					step = 1'b1;
					if (upd.fire && pend_valid_q) begin
						out_load = 1'b1;
					end
					if (visit_last) begin
						state_d = pst_pkg::ST_FLUSH;
					end
				end
			end
			pst_pkg::ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = pst_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_d.last = 1'b1;
					state_d    = pst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pst_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pst_pkg::ST_IDLE;
			used_q       <= '0;
			idx_q        <= '0;
			rsp_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			for (int i = 0; i < pst_pkg::SLOTS; i++) begin
				handle_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (add_we) begin
				handle_q[used_q[pst_pkg::SLOT_BITS-1:0]] <= req.handle;
				used_q <= used_q + pst_pkg::USED_BITS'(1);
			end
			if (rem_we) begin
				handle_q[req.slot_id[pst_pkg::SLOT_BITS-1:0]] <= '0;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + pst_pkg::SLOT_BITS'(1);
			end
			if (step && upd.fire) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == pst_pkg::ST_FLUSH && out_load) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= out_d;
		end
		if (step && upd.fire) begin
			pend_q.kind <= pst_pkg::KIND_FIRE;
			pend_q.slot <= idx_q;
			pend_q.tag  <= handle_q[idx_q];
			pend_q.ok   <= 1'b1;
			pend_q.last <= 1'b0;
		end
		if (add_we) begin
			count_q[used_q[pst_pkg::SLOT_BITS-1:0]]    <= '0;
			interval_q[used_q[pst_pkg::SLOT_BITS-1:0]] <= req.interval;
		end else if (step && slot_active) begin
			count_q[idx_q] <= upd.count;
		end
	end

endmodule

// ===== tb/tb_periodic_slot_timer.sv =====
// ----------------------------------------------------------------------------
// tb_periodic_slot_timer: self-checking bench for the periodic slot timer
// A queue of scheduled requests feeds a handshake driver, and a shadow timer
// table predicts every reply and fire event as each request is taken. The
// monitor compares each response with the oldest prediction, field by field.
// Directed cases come first, then random traffic with idle bursts and stalls.
// ----------------------------------------------------------------------------
module tb_periodic_slot_timer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int MAX_FIRES  = 16;
	localparam int TAIL_ITEMS = 60;
	localparam int RAND_ITEMS = 458;

	typedef struct {
		pst_pkg::req_t r;
		bit            drain;
	} sched_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	pst_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	pst_pkg::rsp_t rsp;

	sched_req_t pending_req[$];
	pst_pkg::rsp_t expected_rsp[$];

	logic [pst_pkg::HANDLE_BITS-1:0] tbl_handle[pst_pkg::SLOTS];
	logic [pst_pkg::IVAL_BITS-1:0]   tbl_count[pst_pkg::SLOTS];
	logic [pst_pkg::IVAL_BITS-1:0]   tbl_interval[pst_pkg::SLOTS];
	int tbl_used;

	int n_accepted;
	int n_checked;
	int n_fires;
	int n_add_full;
	int n_bad_remove;
	int fail_count;
	int send_gap;
	int stall_left;

	periodic_slot_timer uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void predict_timer(pst_pkg::req_t r);
		pst_pkg::rsp_t fires[$];
		pst_pkg::rsp_t one;
		int i;
		one = '0;
		case (r.cmd)
			pst_pkg::CMD_TICK: begin
				for (i = 0; i < tbl_used && i < pst_pkg::SLOTS; i++) begin
					if (tbl_handle[i] != '0) begin
						tbl_count[i] = tbl_count[i] + pst_pkg::IVAL_BITS'(1);
						if (tbl_interval[i] != '0 && tbl_count[i] == tbl_interval[i]) begin
							tbl_count[i] = '0;
							if (fires.size() < MAX_FIRES) begin
								one = '0;
								one.kind = pst_pkg::KIND_FIRE;
								one.slot = pst_pkg::SLOT_BITS'(i);
								one.tag = tbl_handle[i];
								one.ok = 1'b1;
								fires.push_back(one);
							end
						end
					end
				end
				for (i = 0; i < fires.size(); i++) begin
					one = fires[i];
					one.last = (i == fires.size() - 1);
					expected_rsp.push_back(one);
					n_fires++;
				end
			end
			pst_pkg::CMD_ADD: begin
				one.kind = pst_pkg::KIND_ADD;
				one.last = 1'b1;
				if (tbl_used < pst_pkg::SLOTS) begin
					tbl_handle[tbl_used] = r.handle;
					tbl_interval[tbl_used] = r.interval;
					tbl_count[tbl_used] = '0;
					one.slot = pst_pkg::SLOT_BITS'(tbl_used);
					one.ok = 1'b1;
					tbl_used++;
				end else begin
					n_add_full++;
				end
				expected_rsp.push_back(one);
			end
			pst_pkg::CMD_REMOVE: begin
				one.kind = pst_pkg::KIND_REMOVE;
				one.last = 1'b1;
				if (int'(r.slot_id) < tbl_used) begin
					tbl_handle[r.slot_id] = '0;
					one.ok = 1'b1;
				end else begin
					n_bad_remove++;
				end
				expected_rsp.push_back(one);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_response(pst_pkg::rsp_t got);
		pst_pkg::rsp_t want;
		if (expected_rsp.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected response: kind=%0d slot=%0d tag=%h ok=%b last=%b",
					got.kind, got.slot, got.tag, got.ok, got.last);
			return;
		end
		want = expected_rsp.pop_front();
		n_checked++;
		if (got.kind !== want.kind || got.slot !== want.slot || got.tag !== want.tag ||
			got.ok !== want.ok || got.last !== want.last) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("mismatch on response %0d: expected kind=%0d slot=%0d tag=%h ok=%b last=%b",
					n_checked, want.kind, want.slot, want.tag, want.ok, want.last);
				$display("    got kind=%0d slot=%0d tag=%h ok=%b last=%b",
					got.kind, got.slot, got.tag, got.ok, got.last);
			end
		end
	endfunction

	function automatic void schedule(logic [1:0] cmd, logic [pst_pkg::IVAL_BITS-1:0] ival,
		logic [pst_pkg::HANDLE_BITS-1:0] hnd, logic [4:0] id, bit drain);
		sched_req_t s;
		s.r.cmd = cmd;
		s.r.interval = ival;
		s.r.handle = hnd;
		s.r.slot_id = id;
		s.drain = drain;
		pending_req.push_back(s);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_req_t s;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap = 0;
		end else begin
			if (req_valid && req_ready) begin
				predict_timer(req);
				n_accepted++;
			end
			if (!req_valid || req_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_req.size() == 0 ||
					(pending_req[0].drain && expected_rsp.size() != 0)) begin
					req_valid <= 1'b0;
				end else if (pending_req.size() >= TAIL_ITEMS && ((n_accepted / 48) % 2) == 0 &&
					$urandom_range(0, 3) == 0) begin
					send_gap = $urandom_range(0, 5);
					req_valid <= 1'b0;
				end else begin
					s = pending_req.pop_front();
					req <= s.r;
					req_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_response(rsp);
			if (stall_left != 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (pending_req.size() >= TAIL_ITEMS && ((n_checked / 40) % 2) == 0 &&
				$urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 5);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		int k;
		int pick;
		logic [pst_pkg::IVAL_BITS-1:0] ival;
		logic [pst_pkg::HANDLE_BITS-1:0] hnd;
		for (k = 0; k < pst_pkg::SLOTS; k++) begin
			tbl_handle[k] = '0;
			tbl_count[k] = '0;
			tbl_interval[k] = '0;
		end
		tbl_used = 0;

		schedule(pst_pkg::CMD_TICK, 32'h0, 16'h0, 5'd0, 1'b0);
		schedule(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 1'b0);
		schedule(pst_pkg::CMD_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_ADD, 32'd1, 16'hFFFF, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_ADD, 32'd0, 16'h1234, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'h0001, 5'd31, 1'b0);
		schedule(pst_pkg::CMD_ADD, 32'd3, 16'h0000, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_ADD, 32'd2, 16'h8000, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 1'b0);
		schedule(pst_pkg::CMD_TICK, 32'h0, 16'h0, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_REMOVE, 32'h0, 16'h0, 5'd31, 1'b0);
		schedule(pst_pkg::CMD_REMOVE, 32'h0, 16'h0, 5'd5, 1'b0);
		schedule(pst_pkg::CMD_REMOVE, 32'h0, 16'h0, 5'd4, 1'b0);
		schedule(pst_pkg::CMD_REMOVE, 32'h0, 16'h0, 5'd4, 1'b0);
		schedule(pst_pkg::CMD_TICK, 32'h0, 16'h0, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_REMOVE, 32'h0, 16'h0, 5'd0, 1'b1);
		schedule(pst_pkg::CMD_TICK, 32'h0, 16'h0, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_ADD, 32'd1, 16'hAAAA, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_TICK, 32'h0, 16'h0, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_ADD, 32'd2, 16'h5555, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_TICK, 32'h0, 16'h0, 5'd0, 1'b0);
		schedule(pst_pkg::CMD_TICK, 32'h0, 16'h0, 5'd0, 1'b0);

		for (k = 0; k < RAND_ITEMS; k++) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: ival = '0;
				1: ival = $urandom;
				2: ival = 32'hFFFF_FFFF;
				default: ival = $urandom_range(1, 7);
			endcase
			hnd = ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
			if (pick < 12)
				schedule(pst_pkg::CMD_ADD, ival, hnd, 5'($urandom_range(0, 31)),
					k % 60 == 59);
			else if (pick < 18)
				schedule(pst_pkg::CMD_REMOVE, $urandom, 16'($urandom),
					5'($urandom_range(0, 31)), k % 60 == 59);
			else if (pick < 21)
				schedule(CMD_UNUSED, $urandom, 16'($urandom),
					5'($urandom_range(0, 31)), k % 60 == 59);
			else
				schedule(pst_pkg::CMD_TICK, $urandom, 16'($urandom),
					5'($urandom_range(0, 31)), k % 60 == 59);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_req.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (expected_rsp.size() != 0)
			$display("%0d expected responses never arrived", expected_rsp.size());
		$display("%0d requests taken, %0d responses checked, %0d of them fire events",
			n_accepted, n_checked, n_fires);
		$display("%0d adds refused on a full table, %0d removes with an invalid id, %0d mismatches",
			n_add_full, n_bad_remove, fail_count);
		if (fail_count == 0 && expected_rsp.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d requests waiting and %0d responses outstanding",
			pending_req.size(), expected_rsp.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/pst_pkg.sv
hw/rtl/pst_slot_unit.sv
hw/rtl/periodic_slot_timer.sv
tb/tb_periodic_slot_timer.sv
